### src/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg: shared types and constants of the triangle depth rasterizer
// Item kinds, arithmetic widths and the control structs that go to the shared
// multiply-accumulate and divider units.
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam int SCREEN_W_DEF = 128;
    localparam int SCREEN_H_DEF = 128;

    // Depth of a cleared pixel: -1.0 in Q4.12.
    localparam logic signed [15:0] DEPTH_CLEAR = -16'sd4096;
    localparam logic signed [15:0] DEPTH_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_MIN   = 16'sh8000;

    // Multiplier operand and accumulator widths.
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 30;
    localparam int ACC_W   = 48;

    // Divider widths: remainder, quotient and step counter.
    localparam int DIV_W  = 48;
    localparam int QUO_W  = 29;
    localparam int STEP_W = 5;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_mode;

    typedef struct packed {
        logic      go;
        t_mac_mode mode;
    } t_mac_req;

    typedef struct packed {
        logic              go;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

### src/tdr_ram.sv
// ----------------------------------------------------------------------------
// tdr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/tdr_mac.sv
// ----------------------------------------------------------------------------
// tdr_mac: shared multiply-accumulate unit
// Three-stage pipe: operand register, product register, accumulator.
// ----------------------------------------------------------------------------
module tdr_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tdr_pkg::t_mac_req                       i_req,
    input  logic signed [tdr_pkg::MUL_A_W-1:0]      i_opa,
    input  logic signed [tdr_pkg::MUL_B_W-1:0]      i_opb,
    output logic signed [tdr_pkg::ACC_W-1:0]        o_acc,
    output logic                                    o_done
);

    logic signed [tdr_pkg::MUL_A_W-1:0] r_a;
    logic signed [tdr_pkg::MUL_B_W-1:0] r_b;
    logic signed [tdr_pkg::ACC_W-1:0]   r_prod;
    logic signed [tdr_pkg::ACC_W-1:0]   r_acc;
    tdr_pkg::t_mac_mode                 r_mode1;
    tdr_pkg::t_mac_mode                 r_mode2;
    logic                               r_v1;
    logic                               r_v2;
    logic                               r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_req.go) begin
            r_a     <= i_opa;
            r_b     <= i_opb;
            r_mode1 <= i_req.mode;
        end
        if (r_v1) begin
            r_prod  <= r_a * r_b;
            r_mode2 <= r_mode1;
        end
        if (r_v2) begin
            unique case (r_mode2)
                tdr_pkg::MAC_LOAD: r_acc <= r_prod;
                tdr_pkg::MAC_ADD:  r_acc <= r_acc + r_prod;
                tdr_pkg::MAC_SUB:  r_acc <= r_acc - r_prod;
                default:           r_acc <= r_prod;
            endcase
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_v3;

endmodule

### src/tdr_div.sv
// ----------------------------------------------------------------------------
// tdr_div: shared restoring divider
// Produces one quotient bit per cycle. The caller preloads the upper part of
// the dividend as the starting remainder and the lower bits msb first.
// ----------------------------------------------------------------------------
module tdr_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tdr_pkg::t_div_req                  i_req,
    input  logic [tdr_pkg::DIV_W-1:0]          i_rem,
    input  logic [tdr_pkg::QUO_W-1:0]          i_low,
    input  logic [tdr_pkg::DIV_W-1:0]          i_den,
    output logic                               o_busy,
    output logic [tdr_pkg::QUO_W-1:0]          o_quo
);

    logic [tdr_pkg::DIV_W-1:0]  r_rem;
    logic [tdr_pkg::DIV_W-1:0]  r_den;
    logic [tdr_pkg::QUO_W-1:0]  r_low;
    logic [tdr_pkg::QUO_W-1:0]  r_quo;
    logic [tdr_pkg::STEP_W-1:0] r_left;
    logic                       r_busy;
    logic [tdr_pkg::DIV_W-1:0]  rem_sh;
    logic [tdr_pkg::DIV_W:0]    diff;
    logic                       qbit;

    assign rem_sh = {r_rem[tdr_pkg::DIV_W-2:0], r_low[tdr_pkg::QUO_W-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, r_den};
    assign qbit   = !diff[tdr_pkg::DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.go) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_left == tdr_pkg::STEP_W'(1)) begin
            r_busy <= 1'b0;
        end
        if (i_req.go) begin
            r_rem  <= i_rem;
            r_low  <= i_low;
            r_den  <= i_den;
            r_quo  <= '0;
            r_left <= i_req.steps;
        end else if (r_busy) begin
            r_rem  <= qbit ? diff[tdr_pkg::DIV_W-1:0] : rem_sh;
            r_low  <= r_low << 1;
            r_quo  <= {r_quo[tdr_pkg::QUO_W-2:0], qbit};
            r_left <= r_left - tdr_pkg::STEP_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

### src/triangle_depth_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer: edge-function rasterizer with a z-buffer
// Sequencer around one multiply-accumulate unit, one divider and one
// depth/color RAM.
// ----------------------------------------------------------------------------
// Usage. Items arrive as beats on the s_axis channel; tuser carries the kind
// (clear, draw, read) and tdata the vertices and the read coordinates. Every
// item returns exactly one beat on m_axis. The block takes one item at a time:
// s_axis_tready is high only while the sequencer is idle.
// A clear sweeps the RAM one pixel per cycle and then sends its reply. A read
// returns the stored depth and shade of one pixel. A triangle is first set up
// (area, three reciprocals of z in a 29-step divide); then each pixel of its
// clamped bounding box takes six multiplies for the edges, and each covered
// pixel also three 17-step divides for the barycentrics, three multiplies and
// a 15-step divide for depth.
// After reset the block runs the same clearing pass as a clear item, with
// s_axis_tready low until the pass ends, but sends no reply.
// The result sits in an output register; a new item is accepted while it
// waits, and the sequencer holds its next result until the register frees.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer #(
    parameter int SCREEN_W = tdr_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = tdr_pkg::SCREEN_H_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input beats.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: x0, y0, z0, x1, y1, z1, x2, y2, z2 (16 each),
    // read_x (7), read_y (7), two zero bits.
    input  logic [159:0] s_axis_tdata,
    // tuser: kind (2).
    input  logic [1:0]   s_axis_tuser,
    // Result beats.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: pixel_color (8), pixel_depth (16),
    // pixels_written (15), one zero bit.
    output logic [39:0]  m_axis_tdata,
    // tuser: culled (1).
    output logic [0:0]   m_axis_tuser
);

    localparam int NPIX = SCREEN_W * SCREEN_H;
    localparam int IW   = $clog2(NPIX);
    localparam logic [IW-1:0]          LAST_ADDR = IW'(NPIX - 1);
    localparam logic signed [16:0]     HIX_MAX   = 17'(SCREEN_W * 16);
    localparam logic signed [16:0]     HIY_MAX   = 17'(SCREEN_H * 16);
    localparam logic [10:0]            W_L       = 11'(SCREEN_W);
    localparam logic [10:0]            H_L       = 11'(SCREEN_H);
    localparam logic [tdr_pkg::ACC_W-1:0] S_SAT  = tdr_pkg::ACC_W'(64'd1 << 29);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD0, S_RD1, S_MGO, S_MWAIT, S_DGO, S_DWAIT,
        S_BOX, S_COL, S_ROW, S_ZCALC, S_CMP, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        J_AREA_A, J_AREA_B, J_W0_A, J_W0_B, J_W1_A, J_W1_B,
        J_W2_A, J_W2_B, J_S0, J_S1, J_S2
    } t_job;

    typedef enum logic [1:0] {
        D_INV, D_BARY, D_Z
    } t_dsel;

    // ---------------------------------------------------------------- state
    t_state                   r_state;
    t_job                     r_job;
    t_dsel                    r_dsel;
    logic [1:0]               r_k;
    logic                     r_clr_reply;
    logic [IW-1:0]            r_addr;

    logic signed [15:0]       r_x [3];
    logic signed [15:0]       r_y [3];
    logic signed [15:0]       r_z [3];
    logic signed [36:0]       r_area;
    logic signed [36:0]       r_w [3];
    logic [16:0]              r_b [3];
    logic signed [29:0]       r_inv [3];
    logic signed [tdr_pkg::ACC_W-1:0] r_s;
    logic [tdr_pkg::ACC_W-1:0]        r_sabs;
    logic signed [15:0]       r_znew;
    logic [11:0]              r_i;
    logic [11:0]              r_j;
    logic [11:0]              r_jlo;
    logic signed [16:0]       r_hix;
    logic signed [16:0]       r_hiy;
    logic [14:0]              r_cnt;

    logic [7:0]               r_res_color;
    logic signed [15:0]       r_res_depth;
    logic                     r_res_culled;

    logic                     r_ov;
    logic [7:0]               r_o_color;
    logic [15:0]              r_o_depth;
    logic [14:0]              r_o_cnt;
    logic                     r_o_culled;

    // ------------------------------------------------------------ datapath
    tdr_pkg::t_mac_req                  mac_req;
    logic signed [tdr_pkg::MUL_A_W-1:0] opa;
    logic signed [tdr_pkg::MUL_B_W-1:0] opb;
    logic signed [tdr_pkg::ACC_W-1:0]   mac_acc;
    logic                               mac_done;

    tdr_pkg::t_div_req                  div_req;
    logic [tdr_pkg::DIV_W-1:0]          div_rem;
    logic [tdr_pkg::QUO_W-1:0]          div_low;
    logic [tdr_pkg::DIV_W-1:0]          div_den;
    logic                               div_busy;
    logic [tdr_pkg::QUO_W-1:0]          div_quo;

    logic                     ram_we;
    logic [23:0]              ram_wdata;
    logic [23:0]              ram_rdata;
    logic signed [15:0]       rd_depth;

    logic signed [16:0]       px;
    logic signed [16:0]       py;
    logic [16:0]              zabs;
    logic signed [tdr_pkg::ACC_W-1:0] acc_neg;
    logic signed [24:0]       shade_prod;
    logic [7:0]               shade;
    logic                     z_wins;
    logic                     out_load;

    logic signed [15:0]       lox, hix, loy, hiy;
    logic [6:0]               in_rx, in_ry;

    function automatic logic signed [17:0] dif(input logic signed [16:0] a,
                                               input logic signed [16:0] b);
        return {a[16], a} - {b[16], b};
    endfunction

    function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
        return {v[15], v};
    endfunction

    function automatic logic signed [29:0] sx30(input logic signed [17:0] v);
        return {{12{v[17]}}, v};
    endfunction

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    assign px = $signed({1'b0, r_i, 4'b0});
    assign py = $signed({1'b0, r_j, 4'b0});

    // Operand selection for each multiply job. Edge functions are
    // (px - ax)*(by - ay) - (py - ay)*(bx - ax), split into two jobs.
    always_comb begin
        opa          = '0;
        opb          = '0;
        mac_req.go   = (r_state == S_MGO);
        mac_req.mode = tdr_pkg::MAC_LOAD;
        unique case (r_job)
            J_AREA_A: begin
                opa = dif(sx17(r_x[2]), sx17(r_x[0]));
                opb = sx30(dif(sx17(r_y[1]), sx17(r_y[0])));
            end
            J_AREA_B: begin
                opa = dif(sx17(r_y[2]), sx17(r_y[0]));
                opb = sx30(dif(sx17(r_x[1]), sx17(r_x[0])));
                mac_req.mode = tdr_pkg::MAC_SUB;
            end
            J_W0_A: begin
                opa = dif(px, sx17(r_x[1]));
                opb = sx30(dif(sx17(r_y[2]), sx17(r_y[1])));
            end
            J_W0_B: begin
                opa = dif(py, sx17(r_y[1]));
                opb = sx30(dif(sx17(r_x[2]), sx17(r_x[1])));
                mac_req.mode = tdr_pkg::MAC_SUB;
            end
            J_W1_A: begin
                opa = dif(px, sx17(r_x[2]));
                opb = sx30(dif(sx17(r_y[0]), sx17(r_y[2])));
            end
            J_W1_B: begin
                opa = dif(py, sx17(r_y[2]));
                opb = sx30(dif(sx17(r_x[0]), sx17(r_x[2])));
                mac_req.mode = tdr_pkg::MAC_SUB;
            end
            J_W2_A: begin
                opa = dif(px, sx17(r_x[0]));
                opb = sx30(dif(sx17(r_y[1]), sx17(r_y[0])));
            end
            J_W2_B: begin
                opa = dif(py, sx17(r_y[0]));
                opb = sx30(dif(sx17(r_x[1]), sx17(r_x[0])));
                mac_req.mode = tdr_pkg::MAC_SUB;
            end
            J_S0: begin
                opa = $signed({1'b0, r_b[0]});
                opb = r_inv[0];
            end
            J_S1: begin
                opa = $signed({1'b0, r_b[1]});
                opb = r_inv[1];
                mac_req.mode = tdr_pkg::MAC_ADD;
            end
            J_S2: begin
                opa = $signed({1'b0, r_b[2]});
                opb = r_inv[2];
                mac_req.mode = tdr_pkg::MAC_ADD;
            end
            default: begin
                opa = '0;
            end
        endcase
    end

    // Divider operands. The reciprocal is 2^28 / |z|, the barycentric is
    // (w << 16) / area and the depth is 2^44 / |s| when it cannot saturate.
    assign zabs = r_z[r_k][15] ? (17'd0 - {1'b1, r_z[r_k]}) : {1'b0, r_z[r_k]};

    always_comb begin
        div_rem       = '0;
        div_low       = '0;
        div_den       = '0;
        div_req.go    = (r_state == S_DGO);
        div_req.steps = '0;
        unique case (r_dsel)
            D_INV: begin
                div_low       = {1'b1, {(tdr_pkg::QUO_W-1){1'b0}}};
                div_den       = tdr_pkg::DIV_W'(zabs);
                div_req.steps = tdr_pkg::STEP_W'(29);
            end
            D_BARY: begin
                div_rem       = {12'd0, r_w[r_k][36:1]};
                div_low       = {r_w[r_k][0], {(tdr_pkg::QUO_W-1){1'b0}}};
                div_den       = {11'd0, r_area};
                div_req.steps = tdr_pkg::STEP_W'(17);
            end
            D_Z: begin
                div_rem       = S_SAT;
                div_den       = r_sabs;
                div_req.steps = tdr_pkg::STEP_W'(15);
            end
            default: begin
                div_den = r_sabs;
            end
        endcase
    end

    assign acc_neg = -mac_acc;

    // Depth test and shade 255*(z+1)/2, saturated to 0..255.
    assign rd_depth   = $signed(ram_rdata[23:8]);
    assign z_wins     = (r_znew > rd_depth);
    assign shade_prod = ({{9{r_znew[15]}}, r_znew} + 25'sd4096) * 25'sd255;
    always_comb begin
        if (shade_prod < 0) begin
            shade = 8'd0;
        end else if (shade_prod[24:13] > 12'd255) begin
            shade = 8'd255;
        end else begin
            shade = shade_prod[20:13];
        end
    end

    assign ram_we    = (r_state == S_CLR) || (r_state == S_CMP && z_wins);
    assign ram_wdata = (r_state == S_CLR) ? {tdr_pkg::DEPTH_CLEAR, 8'd0}
                                          : {r_znew, shade};

    // The output register takes a new result when it is empty or being read.
    assign out_load = (r_state == S_DONE) && (!r_ov || m_axis_tready);

    // Bounding box; this clamps the low corner to the screen, S_BOX the high one.
    always_comb begin
        lox = min3(r_x[0], r_x[1], r_x[2]);
        hix = max3(r_x[0], r_x[1], r_x[2]);
        loy = min3(r_y[0], r_y[1], r_y[2]);
        hiy = max3(r_y[0], r_y[1], r_y[2]);
        if (lox < 0) begin
            lox = '0;
        end
        if (loy < 0) begin
            loy = '0;
        end
    end

    assign in_rx = s_axis_tdata[150:144];
    assign in_ry = s_axis_tdata[157:151];

    // ----------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_clr_reply <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_addr == LAST_ADDR) begin
                        r_addr  <= '0;
                        r_state <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_res_color  <= '0;
                        r_res_depth  <= '0;
                        r_res_culled <= 1'b0;
                        r_cnt        <= '0;
                        r_x[0] <= s_axis_tdata[15:0];
                        r_y[0] <= s_axis_tdata[31:16];
                        r_z[0] <= s_axis_tdata[47:32];
                        r_x[1] <= s_axis_tdata[63:48];
                        r_y[1] <= s_axis_tdata[79:64];
                        r_z[1] <= s_axis_tdata[95:80];
                        r_x[2] <= s_axis_tdata[111:96];
                        r_y[2] <= s_axis_tdata[127:112];
                        r_z[2] <= s_axis_tdata[143:128];
                        unique case (tdr_pkg::t_kind'(s_axis_tuser))
                            tdr_pkg::KIND_CLEAR: begin
                                r_addr      <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            tdr_pkg::KIND_DRAW: begin
                                r_job   <= J_AREA_A;
                                r_state <= S_MGO;
                            end
                            tdr_pkg::KIND_READ: begin
                                if ({4'd0, in_rx} < W_L && {4'd0, in_ry} < H_L) begin
                                    r_addr  <= IW'(in_ry * SCREEN_W + in_rx);
                                    r_state <= S_RD0;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_res_color <= ram_rdata[7:0];
                    r_res_depth <= rd_depth;
                    r_state     <= S_DONE;
                end
                S_MGO: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mac_done) begin
                        unique case (r_job)
                            J_AREA_B: begin
                                if (mac_acc <= 0 || r_z[0] == 0 || r_z[1] == 0
                                    || r_z[2] == 0) begin
                                    r_res_culled <= 1'b1;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_area  <= mac_acc[36:0];
                                    r_k     <= 2'd0;
                                    r_dsel  <= D_INV;
                                    r_state <= S_DGO;
                                end
                            end
                            J_W0_B: begin
                                r_w[0]  <= mac_acc[36:0];
                                r_job   <= J_W1_A;
                                r_state <= S_MGO;
                            end
                            J_W1_B: begin
                                r_w[1]  <= mac_acc[36:0];
                                r_job   <= J_W2_A;
                                r_state <= S_MGO;
                            end
                            J_W2_B: begin
                                r_w[2] <= mac_acc[36:0];
                                if (r_w[0] < 0 || r_w[1] < 0 || mac_acc < 0) begin
                                    r_j     <= r_j + 12'd1;
                                    r_state <= S_ROW;
                                end else begin
                                    r_k     <= 2'd0;
                                    r_dsel  <= D_BARY;
                                    r_state <= S_DGO;
                                end
                            end
                            J_S2: begin
                                r_s     <= mac_acc;
                                r_sabs  <= mac_acc[tdr_pkg::ACC_W-1] ? acc_neg : mac_acc;
                                r_state <= S_ZCALC;
                            end
                            default: begin
                                r_job   <= t_job'(r_job + 4'd1);
                                r_state <= S_MGO;
                            end
                        endcase
                    end
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (!div_busy) begin
                        unique case (r_dsel)
                            D_INV: begin
                                r_inv[r_k] <= r_z[r_k][15] ? -$signed({1'b0, div_quo})
                                                           : $signed({1'b0, div_quo});
                                r_k     <= r_k + 2'd1;
                                r_state <= (r_k == 2'd2) ? S_BOX : S_DGO;
                            end
                            D_BARY: begin
                                r_b[r_k] <= div_quo[16:0];
                                r_k      <= r_k + 2'd1;
                                if (r_k == 2'd2) begin
                                    r_job   <= J_S0;
                                    r_state <= S_MGO;
                                end else begin
                                    r_state <= S_DGO;
                                end
                            end
                            default: begin
                                r_znew  <= r_s[tdr_pkg::ACC_W-1]
                                           ? -$signed({1'b0, div_quo[14:0]})
                                           : $signed({1'b0, div_quo[14:0]});
                                r_state <= S_CMP;
                            end
                        endcase
                    end
                end
                S_BOX: begin
                    r_i     <= lox[15:4];
                    r_jlo   <= loy[15:4];
                    r_hix   <= (sx17(hix) > HIX_MAX) ? HIX_MAX : sx17(hix);
                    r_hiy   <= (sx17(hiy) > HIY_MAX) ? HIY_MAX : sx17(hiy);
                    r_state <= S_COL;
                end
                S_COL: begin
                    if (px < r_hix) begin
                        r_j     <= r_jlo;
                        r_state <= S_ROW;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ROW: begin
                    if (py < r_hiy) begin
                        r_addr  <= IW'(r_j * SCREEN_W + r_i);
                        r_job   <= J_W0_A;
                        r_state <= S_MGO;
                    end else begin
                        r_i     <= r_i + 12'd1;
                        r_state <= S_COL;
                    end
                end
                S_ZCALC: begin
                    // A zero sum takes the maximum depth; a small one saturates.
                    if (r_s == 0) begin
                        r_znew  <= tdr_pkg::DEPTH_MAX;
                        r_state <= S_CMP;
                    end else if (r_sabs <= S_SAT) begin
                        r_znew  <= r_s[tdr_pkg::ACC_W-1] ? tdr_pkg::DEPTH_MIN
                                                         : tdr_pkg::DEPTH_MAX;
                        r_state <= S_CMP;
                    end else begin
                        r_dsel  <= D_Z;
                        r_state <= S_DGO;
                    end
                end
                S_CMP: begin
                    if (z_wins && r_cnt != 15'h7FFF) begin
                        r_cnt <= r_cnt + 15'd1;
                    end
                    r_j     <= r_j + 12'd1;
                    r_state <= S_ROW;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_o_color   <= r_res_color;
                        r_o_depth   <= r_res_depth;
                        r_o_cnt     <= r_cnt;
                        r_o_culled  <= r_res_culled;
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // --------------------------------------------------------------- units
    tdr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_opa   (opa),
        .i_opb   (opb),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    tdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_rem   (div_rem),
        .i_low   (div_low),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Depth in the upper 16 bits, shade in the lower 8.
    tdr_ram #(
        .WIDTH (24),
        .DEPTH (NPIX)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (r_addr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rdata)
    );

    // ------------------------------------------------------------- outputs
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_o_cnt, r_o_depth, r_o_color};
    assign m_axis_tuser  = r_o_culled;

`ifndef SYNTHESIS
    // Reset always starts the clearing pass, so no item is taken right after.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready) else $error("item accepted after reset");

    // A culled triangle reports nothing besides the flag.
    a_culled_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
        else $error("culled result carries data");

    // The shared divider is never restarted while it runs.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.go |-> !div_busy) else $error("divider restarted while busy");

    // The depth test follows a finished depth computation.
    a_cmp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> $past(r_state) == S_DWAIT || $past(r_state) == S_ZCALC)
        else $error("depth test without a depth");
`endif

endmodule
